[sv/sbt_pkg.sv]
// Shared types and constants for the source byte tokenizer.
// Used by the front classifier, the token queue and the top level.
`default_nettype none
package sbt_pkg;

  // Lexing phases.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SLASH   = 4'd1,
    PH_COMMENT = 4'd2,
    PH_OPER    = 4'd3,
    PH_IDENT   = 4'd4,
    PH_INT     = 4'd5,
    PH_DOT     = 4'd6,
    PH_FRAC    = 4'd7,
    PH_STR     = 4'd8,
    PH_ESC     = 4'd9
  } phase_t;

  // Token kinds.
  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_BANG   = 6'd11;
  localparam logic [5:0] K_EQUAL  = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS   = 6'd17;
  localparam logic [5:0] K_IDENT  = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_NUMBER = 6'd21;
  localparam logic [5:0] K_AND    = 6'd22;
  localparam logic [5:0] K_ELSE   = 6'd23;
  localparam logic [5:0] K_FALSE  = 6'd24;
  localparam logic [5:0] K_FUN    = 6'd25;
  localparam logic [5:0] K_IF     = 6'd26;
  localparam logic [5:0] K_NIL    = 6'd27;
  localparam logic [5:0] K_OR     = 6'd28;
  localparam logic [5:0] K_PRINT  = 6'd29;
  localparam logic [5:0] K_RETURN = 6'd30;
  localparam logic [5:0] K_TRUE   = 6'd31;
  localparam logic [5:0] K_VAR    = 6'd32;
  localparam logic [5:0] K_WHILE  = 6'd33;
  localparam logic [5:0] K_ERROR  = 6'd34;
  localparam logic [5:0] K_EOF    = 6'd35;

  // Error codes.
  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_CHAR   = 2'd1;
  localparam logic [1:0] E_NUMBER = 2'd2;
  localparam logic [1:0] E_STRING = 2'd3;

  // Pending operator codes.
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_BANG    = 3'd1;
  localparam logic [2:0] OP_EQUAL   = 3'd2;
  localparam logic [2:0] OP_LESS    = 3'd3;
  localparam logic [2:0] OP_GREATER = 3'd4;

  localparam int MAX_TOK = 4;
  localparam int PREFIX_BITS = 48;

  // Output field widths.
  localparam int KIND_W = 6;
  localparam int LEN_W  = 24;
  localparam int POS_W  = 24;
  localparam int LNO_W  = 20;

  // Keyword lookup over the packed first bytes (first byte low).
  function automatic logic [5:0] word_kind(input logic [PREFIX_BITS-1:0] w,
                                           input logic [2:0] len);
    logic [5:0] k;
    k = K_IDENT;
    case (len)
      3'd2: begin
        if (w == 48'h6669) k = K_IF;
        if (w == 48'h726f) k = K_OR;
      end
      3'd3: begin
        if (w == 48'h646e61) k = K_AND;
        if (w == 48'h6e7566) k = K_FUN;
        if (w == 48'h6c696e) k = K_NIL;
        if (w == 48'h726176) k = K_VAR;
      end
      3'd4: begin
        if (w == 48'h65736c65) k = K_ELSE;
        if (w == 48'h65757274) k = K_TRUE;
      end
      3'd5: begin
        if (w == 48'h65736c6166) k = K_FALSE;
        if (w == 48'h746e697270) k = K_PRINT;
        if (w == 48'h656c696877) k = K_WHILE;
      end
      3'd6: begin
        if (w == 48'h6e7275746572) k = K_RETURN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[sv/sbt_front.sv]
// Front part: accepts source bytes, keeps the lexing state and classifies
// each byte into up to three token records. Depends on sbt_pkg.
`default_nettype none
module sbt_front #(
  parameter int PW = 24,
  parameter int LW = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            c,
  output logic [2:0]                 tok_n,
  output logic [3:0][5:0]            tok_kind,
  output logic [3:0][PW-1:0]         tok_start,
  output logic [3:0][PW-1:0]         tok_len,
  output logic [3:0][LW-1:0]         tok_line,
  output logic [3:0][1:0]            tok_err
);
  import sbt_pkg::*;

  localparam logic [PW-1:0] PMAX = {PW{1'b1}};
  localparam logic [LW-1:0] LMAX = {LW{1'b1}};

  phase_t            phase_r, phase_nxt;
  logic [2:0]        pend_r, pend_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     start_r, start_nxt;
  logic [LW-1:0]     line_r, line_nxt;
  logic [PREFIX_BITS-1:0] word_r, word_nxt;

  logic          is_alpha, is_digit, again, clr;
  logic [PW-1:0] span_p, span_dot, dot_p;
  logic [5:0]    opk;

  assign is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  assign is_digit = c >= 8'h30 && c <= 8'h39;
  assign span_p   = (pos_r > start_r) ? pos_r - start_r : '0;
  assign dot_p    = (pos_r != '0) ? pos_r - 1'b1 : '0;
  assign span_dot = (dot_p > start_r) ? dot_p - start_r : '0;

  always_comb begin
    case (pend_r)
      OP_EQUAL:   opk = K_EQUAL;
      OP_LESS:    opk = K_LESS;
      OP_GREATER: opk = K_GREATER;
      default:    opk = K_BANG;
    endcase
  end

  // Next state and emitted tokens for one byte. Line is sampled per token.
  always_comb begin
    logic [LW-1:0] ln;
    logic [2:0] n;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    start_nxt = start_r;
    word_nxt  = word_r;
    ln        = line_r;
    n         = '0;
    again     = 1'b0;
    clr       = 1'b0;
    tok_kind  = '0;
    tok_start = '0;
    tok_len   = '0;
    tok_line  = '0;
    tok_err   = '0;
    case (phase_r)
      PH_IDLE: again = 1'b1;
      PH_SLASH: begin
        if (c == 8'h2f) phase_nxt = PH_COMMENT;
        else begin
          tok_kind[n] = K_SLASH; tok_start[n] = start_r; tok_len[n] = PW'(1);
          tok_line[n] = ln; n = n + 1'b1; again = 1'b1;
        end
      end
      PH_COMMENT: again = (c == 8'h0a || c == 8'h00);
      PH_OPER: begin
        pend_nxt = OP_NONE;
        tok_start[n] = start_r; tok_line[n] = ln;
        if (c == 8'h3d) begin
          tok_kind[n] = opk + 6'd1; tok_len[n] = PW'(2); phase_nxt = PH_IDLE;
        end else begin
          tok_kind[n] = opk; tok_len[n] = PW'(1); again = 1'b1;
        end
        n = n + 1'b1;
      end
      PH_IDENT: begin
        if (is_alpha || is_digit) begin
          if (span_p < PW'(6))
            word_nxt = word_r | (PREFIX_BITS'(c) << {span_p[2:0], 3'b000});
        end else begin
          tok_kind[n]  = (span_p < PW'(7)) ? word_kind(word_r, span_p[2:0]) : K_IDENT;
          tok_start[n] = start_r; tok_len[n] = span_p; tok_line[n] = ln;
          n = n + 1'b1; again = 1'b1;
        end
      end
      PH_INT, PH_FRAC: begin
        if (is_digit) begin
        end else if (c == 8'h2e && phase_r == PH_INT) phase_nxt = PH_DOT;
        else begin
          tok_start[n] = start_r; tok_line[n] = ln;
          if (is_alpha) begin
            tok_kind[n] = K_ERROR; tok_err[n] = E_NUMBER;
          end else begin
            tok_kind[n] = K_NUMBER; tok_len[n] = span_p;
          end
          n = n + 1'b1; again = 1'b1;
        end
      end
      PH_DOT: begin
        if (is_digit) phase_nxt = PH_FRAC;
        else begin
          tok_kind[n] = K_NUMBER; tok_start[n] = start_r; tok_len[n] = span_dot;
          tok_line[n] = ln; n = n + 1'b1;
          tok_kind[n] = K_DOT; tok_start[n] = dot_p; tok_len[n] = PW'(1);
          tok_line[n] = ln; n = n + 1'b1; again = 1'b1;
        end
      end
      PH_STR, PH_ESC: begin
        if (c == 8'h00) begin
          tok_kind[n] = K_ERROR; tok_start[n] = start_r; tok_err[n] = E_STRING;
          tok_line[n] = ln; n = n + 1'b1; again = 1'b1;
        end else if (phase_r == PH_ESC) begin
          if (c == 8'h0a && ln < LMAX) ln = ln + 1'b1;
          phase_nxt = PH_STR;
        end else if (c == 8'h5c) phase_nxt = PH_ESC;
        else if (c == 8'h22) begin
          tok_kind[n] = K_STRING; tok_start[n] = start_r; tok_len[n] = span_p + 1'b1;
          tok_line[n] = ln; n = n + 1'b1; phase_nxt = PH_IDLE;
        end else if (c == 8'h0a && ln < LMAX) ln = ln + 1'b1;
      end
      default: again = 1'b1;
    endcase

    // Byte seen from the idle phase.
    if (again) begin
      phase_nxt = PH_IDLE;
      tok_start[n] = pos_r; tok_line[n] = ln; tok_len[n] = PW'(1);
      case (c)
        8'h20, 8'h0d, 8'h09: ;
        8'h0a: if (ln < LMAX) ln = ln + 1'b1;
        8'h00: begin
          tok_kind[n] = K_EOF; tok_len[n] = '0; n = n + 1'b1; clr = 1'b1;
        end
        8'h28: begin tok_kind[n] = K_LPAREN; n = n + 1'b1; end
        8'h29: begin tok_kind[n] = K_RPAREN; n = n + 1'b1; end
        8'h7b: begin tok_kind[n] = K_LBRACE; n = n + 1'b1; end
        8'h7d: begin tok_kind[n] = K_RBRACE; n = n + 1'b1; end
        8'h2c: begin tok_kind[n] = K_COMMA;  n = n + 1'b1; end
        8'h2e: begin tok_kind[n] = K_DOT;    n = n + 1'b1; end
        8'h2d: begin tok_kind[n] = K_MINUS;  n = n + 1'b1; end
        8'h2b: begin tok_kind[n] = K_PLUS;   n = n + 1'b1; end
        8'h3b: begin tok_kind[n] = K_SEMI;   n = n + 1'b1; end
        8'h2a: begin tok_kind[n] = K_STAR;   n = n + 1'b1; end
        8'h2f: begin phase_nxt = PH_SLASH; start_nxt = pos_r; end
        8'h21: begin phase_nxt = PH_OPER; pend_nxt = OP_BANG; start_nxt = pos_r; end
        8'h3d: begin phase_nxt = PH_OPER; pend_nxt = OP_EQUAL; start_nxt = pos_r; end
        8'h3c: begin phase_nxt = PH_OPER; pend_nxt = OP_LESS; start_nxt = pos_r; end
        8'h3e: begin phase_nxt = PH_OPER; pend_nxt = OP_GREATER; start_nxt = pos_r; end
        8'h22: begin phase_nxt = PH_STR; start_nxt = pos_r; end
        default: begin
          if (is_alpha) begin
            phase_nxt = PH_IDENT; start_nxt = pos_r; word_nxt = PREFIX_BITS'(c);
          end else if (is_digit) begin
            phase_nxt = PH_INT; start_nxt = pos_r;
          end else begin
            tok_kind[n] = K_ERROR; tok_len[n] = '0; tok_err[n] = E_CHAR; n = n + 1'b1;
          end
        end
      endcase
    end

    line_nxt = ln;
    pos_nxt  = (c != 8'h00 && pos_r < PMAX) ? pos_r + 1'b1 : pos_r;
    if (clr) begin
      phase_nxt = PH_IDLE; pend_nxt = OP_NONE; pos_nxt = '0; start_nxt = '0;
      line_nxt = LW'(1); word_nxt = '0;
    end
    tok_n = n;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= OP_NONE;
      pos_r   <= '0;
      start_r <= '0;
      line_r  <= LW'(1);
      word_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      line_r  <= line_nxt;
      word_r  <= word_nxt;
    end
  end

  // The line count never drops to zero outside of reset.
  assert property (@(posedge clk) disable iff (!rst_n) line_r != '0)
    else $error("line count reached zero");
  // A pending operator is held only in the operator phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != OP_NONE) |-> (phase_r == PH_OPER))
    else $error("stale pending operator");
  // At most three tokens come from one byte.
  assert property (@(posedge clk) disable iff (!rst_n) tok_n <= 3'd3)
    else $error("too many tokens for one beat");
endmodule
`default_nettype wire

[sv/sbt_queue.sv]
// Token queue between the classifier and the output port; takes up to
// four records in one cycle and hands out one per beat. Depends on sbt_pkg.
`default_nettype none
module sbt_queue #(
  parameter int PW = 24,
  parameter int LW = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic [2:0]            push_n,
  input  wire logic [3:0][5:0]       p_kind,
  input  wire logic [3:0][PW-1:0]    p_start,
  input  wire logic [3:0][PW-1:0]    p_len,
  input  wire logic [3:0][LW-1:0]    p_line,
  input  wire logic [3:0][1:0]       p_err,
  output logic                       room,
  output logic                       q_valid,
  input  wire logic                  pop,
  output logic [5:0]                 q_kind,
  output logic [PW-1:0]              q_start,
  output logic [PW-1:0]              q_len,
  output logic [LW-1:0]              q_line,
  output logic [1:0]                 q_err,
  output logic                       q_last
);
  import sbt_pkg::*;

  localparam int DEPTH = 8;
  localparam int EW = 6 + 2 * PW + LW + 2 + 1;

  logic [DEPTH-1:0][EW-1:0] mem_r;
  logic [2:0] rd_r, wr_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] pushed, popped;

  assign pushed  = push ? {1'b0, push_n} : 4'd0;
  assign popped  = (pop && q_valid) ? 4'd1 : 4'd0;
  assign cnt_nxt = cnt_r + pushed - popped;
  assign room    = cnt_r <= 4'd5;
  assign q_valid = cnt_r != 4'd0;
  assign {q_kind, q_start, q_len, q_line, q_err, q_last} = mem_r[rd_r];

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      rd_r  <= rd_r + popped[2:0];
      wr_r  <= wr_r + pushed[2:0];
      cnt_r <= cnt_nxt;
    end
  end

  // Entry writes; each record lands at its own slot.
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_TOK; i++) begin
        if (3'(i) < push_n)
          mem_r[wr_r + 3'(i)] <= {p_kind[i], p_start[i], p_len[i], p_line[i], p_err[i],
                                  (3'(i) == push_n - 3'd1)};
      end
    end
  end

  // The count never exceeds the depth.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 4'd8)
    else $error("token queue overflow");
  // A push happens only when there is room for it.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> room)
    else $error("push without room");
  // The pointers stay consistent with the count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 4'd0) |-> (rd_r == wr_r))
    else $error("empty queue with unequal pointers");
endmodule
`default_nettype wire

[sv/source_byte_tokenizer_top.sv]
// Source byte tokenizer: one source byte per cycle in while in_stall is low, tokens out.
// A token completed by a byte is registered in the token queue and offered from there.
// Input takes one byte per cycle while the eight-entry token queue has room
// for three more tokens; output drains one token per cycle while out_stall is low.
// Reset (rst_n low, synchronous) returns to line one, position zero, idle.
`default_nettype none
module source_byte_tokenizer_top #(
  parameter int POSITION_BITS = 24,
  parameter int LINE_BITS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_source_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [5:0]                 out_token_kind,
  output logic [23:0]                out_token_start,
  output logic [23:0]                out_token_length,
  output logic [19:0]                out_token_line,
  output logic [1:0]                 out_error_code,
  output logic                       out_last_of_run
);
  import sbt_pkg::*;

  logic                             room, step;
  logic [2:0]                       tok_n;
  logic [3:0][5:0]                  tok_kind;
  logic [3:0][POSITION_BITS-1:0]    tok_start, tok_len;
  logic [3:0][LINE_BITS-1:0]        tok_line;
  logic [3:0][1:0]                  tok_err;
  logic [POSITION_BITS-1:0]         q_start, q_len;
  logic [LINE_BITS-1:0]             q_line;

  assign in_stall = !room;
  assign step     = in_valid && room;

  // Classifier.
  sbt_front #(.PW(POSITION_BITS), .LW(LINE_BITS)) u_front (
    .clk, .rst_n, .step, .c(in_source_byte), .tok_n, .tok_kind,
    .tok_start, .tok_len, .tok_line, .tok_err
  );

  // Token queue feeding the output port.
  sbt_queue #(.PW(POSITION_BITS), .LW(LINE_BITS)) u_queue (
    .clk, .rst_n, .push(step && tok_n != 3'd0), .push_n(tok_n),
    .p_kind(tok_kind), .p_start(tok_start), .p_len(tok_len),
    .p_line(tok_line), .p_err(tok_err), .room, .q_valid(out_valid),
    .pop(!out_stall), .q_kind(out_token_kind), .q_start, .q_len, .q_line,
    .q_err(out_error_code), .q_last(out_last_of_run)
  );

  // Fit the field widths to the fixed port widths.
  assign out_token_start  = 24'(q_start);
  assign out_token_length = 24'(q_len);
  assign out_token_line   = 20'(q_line);
endmodule
`default_nettype wire

[dv/token_checker.sv]
// Token checker for the source byte tokenizer: watches both channels,
// predicts the token stream byte by byte and compares it field by field.
// Depends on sbt_pkg for phase and token kind constants.
`timescale 1ns / 1ps
module token_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_source_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [5:0]  out_token_kind,
  input  wire logic [23:0] out_token_start,
  input  wire logic [23:0] out_token_length,
  input  wire logic [19:0] out_token_line,
  input  wire logic [1:0]  out_error_code,
  input  wire logic        out_last_of_run,
  output int               fail_count,
  output int               tokens_pending
);
  import sbt_pkg::*;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] start;
    logic [23:0] length;
    logic [19:0] line;
    logic [1:0]  err;
    logic        last;
  } token_t;

  localparam logic [23:0] POS_LIMIT = 24'hFFFFFF;
  localparam logic [19:0] LINE_LIMIT = 20'hFFFFF;

  token_t expected_tokens[$];
  token_t step_tokens[$];

  // Predictor state.
  phase_t      phase;
  logic [2:0]  held_op;
  logic [23:0] next_pos;
  logic [23:0] lex_start;
  logic [19:0] line_no;
  logic [47:0] prefix;

  assign tokens_pending = expected_tokens.size();

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [23:0] distance(logic [23:0] a, logic [23:0] b);
    return b > a ? b - a : 24'd0;
  endfunction

  // Exact keyword match on the whole identifier.
  function automatic logic [5:0] keyword_kind(logic [47:0] w, logic [23:0] len);
    logic [5:0] k;
    k = K_IDENT;
    case (len)
      2: if (w == 48'h6669) k = K_IF; else if (w == 48'h726f) k = K_OR;
      3: case (w)
           48'h646e61: k = K_AND;
           48'h6e7566: k = K_FUN;
           48'h6c696e: k = K_NIL;
           48'h726176: k = K_VAR;
           default: k = K_IDENT;
         endcase
      4: if (w == 48'h65736c65) k = K_ELSE; else if (w == 48'h65757274) k = K_TRUE;
      5: case (w)
           48'h65736c6166: k = K_FALSE;
           48'h746e697270: k = K_PRINT;
           48'h656c696877: k = K_WHILE;
           default: k = K_IDENT;
         endcase
      6: if (w == 48'h6e7275746572) k = K_RETURN;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  task automatic add_token(logic [5:0] k, logic [23:0] s, logic [23:0] l, logic [1:0] e);
    token_t t;
    t = '{kind: k, start: s, length: l, line: line_no, err: e, last: 1'b0};
    step_tokens.push_back(t);
  endtask

  task automatic bump_line();
    if (line_no < LINE_LIMIT) line_no++;
  endtask

  task automatic reset_state();
    phase = PH_IDLE;
    held_op = OP_NONE;
    next_pos = '0;
    lex_start = '0;
    line_no = 20'd1;
    prefix = '0;
  endtask

  // A byte seen between tokens.
  task automatic start_token(logic [7:0] c, logic [23:0] p);
    phase = PH_IDLE;
    case (c)
      " ", 8'h0d, "\t": ;
      "\n": bump_line();
      8'd0: begin
        add_token(K_EOF, p, 24'd0, E_NONE);
        reset_state();
      end
      "(": add_token(K_LPAREN, p, 24'd1, E_NONE);
      ")": add_token(K_RPAREN, p, 24'd1, E_NONE);
      "{": add_token(K_LBRACE, p, 24'd1, E_NONE);
      "}": add_token(K_RBRACE, p, 24'd1, E_NONE);
      ",": add_token(K_COMMA, p, 24'd1, E_NONE);
      ".": add_token(K_DOT, p, 24'd1, E_NONE);
      "-": add_token(K_MINUS, p, 24'd1, E_NONE);
      "+": add_token(K_PLUS, p, 24'd1, E_NONE);
      ";": add_token(K_SEMI, p, 24'd1, E_NONE);
      "*": add_token(K_STAR, p, 24'd1, E_NONE);
      "/": begin phase = PH_SLASH; lex_start = p; end
      "!": begin phase = PH_OPER; held_op = OP_BANG; lex_start = p; end
      "=": begin phase = PH_OPER; held_op = OP_EQUAL; lex_start = p; end
      "<": begin phase = PH_OPER; held_op = OP_LESS; lex_start = p; end
      ">": begin phase = PH_OPER; held_op = OP_GREATER; lex_start = p; end
      "\"": begin phase = PH_STR; lex_start = p; end
      default: begin
        if (is_letter(c)) begin
          phase = PH_IDENT;
          lex_start = p;
          prefix = {40'd0, c};
        end else if (is_num(c)) begin
          phase = PH_INT;
          lex_start = p;
        end else begin
          add_token(K_ERROR, p, 24'd0, E_CHAR);
        end
      end
    endcase
  endtask

  // Predict the tokens that one accepted byte completes.
  task automatic predict_tokens(logic [7:0] c);
    logic [23:0] p;
    logic [23:0] len;
    logic [23:0] dot;
    logic [5:0]  k;
    bit          redo;
    p = next_pos;
    redo = 0;
    step_tokens.delete();
    case (phase)
      PH_IDLE: redo = 1;
      PH_SLASH:
        if (c == "/") phase = PH_COMMENT;
        else begin
          add_token(K_SLASH, lex_start, 24'd1, E_NONE);
          redo = 1;
        end
      PH_COMMENT: redo = (c == "\n" || c == 8'd0);
      PH_OPER: begin
        case (held_op)
          OP_EQUAL: k = K_EQUAL;
          OP_LESS: k = K_LESS;
          OP_GREATER: k = K_GREATER;
          default: k = K_BANG;
        endcase
        held_op = OP_NONE;
        if (c == "=") begin
          add_token(k + 6'd1, lex_start, 24'd2, E_NONE);
          phase = PH_IDLE;
        end else begin
          add_token(k, lex_start, 24'd1, E_NONE);
          redo = 1;
        end
      end
      PH_IDENT: begin
        len = distance(lex_start, p);
        if (is_letter(c) || is_num(c)) begin
          if (len < 6) prefix[8*len +: 8] = c;
        end else begin
          add_token(keyword_kind(prefix, len), lex_start, len, E_NONE);
          redo = 1;
        end
      end
      PH_INT, PH_FRAC: begin
        if (is_num(c)) ;
        else if (c == "." && phase == PH_INT) phase = PH_DOT;
        else begin
          if (is_letter(c)) add_token(K_ERROR, lex_start, 24'd0, E_NUMBER);
          else add_token(K_NUMBER, lex_start, distance(lex_start, p), E_NONE);
          redo = 1;
        end
      end
      PH_DOT: begin
        if (is_num(c)) phase = PH_FRAC;
        else begin
          dot = p > 0 ? p - 24'd1 : 24'd0;
          add_token(K_NUMBER, lex_start, distance(lex_start, dot), E_NONE);
          add_token(K_DOT, dot, 24'd1, E_NONE);
          redo = 1;
        end
      end
      PH_STR, PH_ESC: begin
        if (c == 8'd0) begin
          add_token(K_ERROR, lex_start, 24'd0, E_STRING);
          redo = 1;
        end else if (phase == PH_ESC) begin
          if (c == "\n") bump_line();
          phase = PH_STR;
        end else if (c == "\\") phase = PH_ESC;
        else if (c == "\"") begin
          add_token(K_STRING, lex_start, distance(lex_start, p) + 24'd1, E_NONE);
          phase = PH_IDLE;
        end else if (c == "\n") bump_line();
      end
      default: redo = 1;
    endcase
    if (redo) start_token(c, p);
    if (c != 8'd0 && next_pos < POS_LIMIT) next_pos++;
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("token mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      reset_state();
      expected_tokens.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected beat, kind", {18'd0, out_token_kind}, 24'd0);
        end else begin
          want = expected_tokens.pop_front();
          if (out_token_kind !== want.kind)
            report_mismatch("kind", {18'd0, out_token_kind}, {18'd0, want.kind});
          if (out_token_start !== want.start) report_mismatch("start", out_token_start, want.start);
          if (out_token_length !== want.length)
            report_mismatch("length", out_token_length, want.length);
          if (out_token_line !== want.line)
            report_mismatch("line", {4'd0, out_token_line}, {4'd0, want.line});
          if (out_error_code !== want.err)
            report_mismatch("error", {22'd0, out_error_code}, {22'd0, want.err});
          if (out_last_of_run !== want.last)
            report_mismatch("last", {23'd0, out_last_of_run}, {23'd0, want.last});
        end
      end
      if (in_valid && !in_stall) predict_tokens(in_source_byte);
    end
  end
endmodule

[dv/tb.sv]
// Testbench top for the source byte tokenizer: clock, reset, byte stimulus
// with bursty sending and receiver stalls, and the final verdict.
// Depends on sbt_pkg, source_byte_tokenizer_top and token_checker.
`timescale 1ns / 1ps
module tb;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_source_byte;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_token_kind;
  logic [23:0] out_token_start;
  logic [23:0] out_token_length;
  logic [19:0] out_token_line;
  logic [1:0]  out_error_code;
  logic        out_last_of_run;
  int          fail_count;
  int          tokens_pending;
  bit          hold_request;
  bit          long_hold_done;

  byte unsigned source_text[$];

  source_byte_tokenizer_top uut (.*);
  token_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
  endtask

  // Random fragment: mostly well formed lexemes, sometimes noise.
  task automatic add_fragment();
    string words[14];
    string ops[8];
    int sel;
    words = '{"and", "else", "false", "fun", "if", "nil", "or", "print", "return",
              "true", "var", "while", "andx", "_Zq9"};
    ops = '{"!=", "==", "<=", ">=", "!", "=", "<", ">"};
    sel = $urandom_range(0, 11);
    case (sel)
      0, 1: add_text(words[$urandom_range(0, 13)]);
      2: begin
        repeat ($urandom_range(1, 8)) source_text.push_back(
          $urandom_range(0, 1) ? $urandom_range("a", "z") : $urandom_range("0", "9"));
      end
      3: begin
        repeat ($urandom_range(1, 3)) source_text.push_back($urandom_range("0", "9"));
        if ($urandom_range(0, 1)) begin
          source_text.push_back(".");
          if ($urandom_range(0, 2) != 0) source_text.push_back($urandom_range("0", "9"));
        end
        if ($urandom_range(0, 3) == 0) source_text.push_back("e");
      end
      4: add_text(ops[$urandom_range(0, 7)]);
      5: begin
        source_text.push_back("\"");
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 4))
            0: source_text.push_back("\\");
            1: source_text.push_back("\n");
            default: source_text.push_back($urandom_range(1, 255));
          endcase
        end
        if ($urandom_range(0, 5) != 0) source_text.push_back("\"");
      end
      6: begin
        add_text("// ");
        repeat ($urandom_range(0, 4)) source_text.push_back($urandom_range(1, 255));
        source_text.push_back("\n");
      end
      7: add_text("(){},.-+;*/");
      8: source_text.push_back($urandom_range(1, 255));
      9: source_text.push_back($urandom_range(128, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: source_text.push_back(" ");
          1: source_text.push_back("\n");
          2: source_text.push_back("\t");
          default: source_text.push_back(8'h0d);
        endcase
      end
    endcase
    if ($urandom_range(0, 2) == 0) source_text.push_back(" ");
  endtask

  // Receiver: own stall pattern, plus one long hold-off on request.
  initial begin
    int mode;
    out_stall <= 1'b0;
    long_hold_done = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !long_hold_done) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        long_hold_done = 1;
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // Sender: bursts of bytes with random gaps.
  initial begin
    int burst;
    int idx;
    in_valid <= 1'b0;
    in_source_byte <= 8'd0;
    rst_n <= 1'b0;
    hold_request = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed source: every operator, keywords, number cases, strings, errors.
    add_text("( ) { } , . - + ; * / != == <= >= ! = < > // note\n");
    source_text.push_back(0);
    add_text("x and elsee 12.5 3. 7a \"a\\\"b\" @");
    source_text.push_back(8'hFF);
    source_text.push_back(0);
    add_text("\"open\\");
    source_text.push_back(0);
    add_text("3.");
    source_text.push_back(0);
    while (source_text.size() < 460) begin
      add_fragment();
      if ($urandom_range(0, 24) == 0) source_text.push_back(0);
    end
    source_text.push_back(0);

    idx = 0;
    @(posedge clk);
    while (idx < source_text.size()) begin
      if (idx >= 200) hold_request = 1;
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      while (burst > 0 && idx < source_text.size()) begin
        in_valid <= 1'b1;
        in_source_byte <= source_text[idx];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        idx++;
        burst--;
      end
      if (idx < source_text.size() && $urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        in_source_byte <= $urandom_range(0, 255);
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep waiting for any stray beat.
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
